>>> sv/fhsd_pkg.sv
// ----------------------------------------------------------------------------
// fhsd_pkg
// Shared constants and types of the frame header sync deframer.
// ----------------------------------------------------------------------------
package fhsd_pkg;

  localparam int HEADER_BYTES = 20;
  localparam int NUM_SCHEMES  = 5;
  localparam int HOLD_DEPTH   = 7;
  // the last held byte is checked as it arrives, so only the first ones are stored
  localparam int WIN_DEPTH    = HOLD_DEPTH - 1;
  localparam int HOLD_CNT_W   = $clog2(HOLD_DEPTH);
  localparam int REL_IDX_W    = $clog2(HOLD_DEPTH);
  localparam int LEN_W        = 11;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PAYLOAD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME   = 1'd1;
  localparam logic [LEN_W-1:0] MIN_PAYLOAD_RST = 11'd46;
  localparam logic [LEN_W-1:0] MAX_FRAME_RST   = 11'd1500;

  localparam logic [1:0] SEC_HEADER  = 2'd0;
  localparam logic [1:0] SEC_PAYLOAD = 2'd1;
  localparam logic [1:0] SEC_TRAILER = 2'd2;

  localparam logic KIND_PASS    = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam int Q_DEPTH = 8;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef logic [7:0] byte_t;

  // one queue entry: a single passed byte, or all held header bytes to release
  typedef struct packed {
    logic                   kind;
    byte_t [HOLD_DEPTH-1:0] bytes;
    logic [1:0]             section;
    logic [2:0]             scheme;
    logic                   last;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

>>> sv/frame_header_sync_deframer.sv
// ----------------------------------------------------------------------------
// frame_header_sync_deframer
// Byte stream deframer: header sync, section tagging and frame marking.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle on the in_ stream as long as its command
// queue (8 entries) has room, and gives one result per cycle from its output
// register while the receiver takes them. While searching it holds the first
// seven bytes of a candidate header and gives nothing; a bad header drops one
// byte and the search slides on. A good header releases the seven held bytes,
// which the back end plays out one after another from a single queue entry,
// and every later byte of the frame then passes through a queue entry and the
// output register. Within a frame the sustained rate is one byte per cycle in
// and out while neither stream stalls. Sizes from min_payload and max_frame are
// taken when a header is accepted; write them only while the block is idle.
// ----------------------------------------------------------------------------
module frame_header_sync_deframer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // rx_byte
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // out_byte
  output logic [7:0]                      out_tuser,  // section[1:0], scheme_id[4:2],
                                                      // frame_first[5]
  output logic                            out_tlast,  // frame_last
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fhsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fhsd_pkg::LEN_W-1:0]      cfg_data
);
  import fhsd_pkg::*;

  q_status_t q_stat;
  q_entry_t  q_wdata, q_head;
  logic      q_push, q_pop;

  fhsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  fhsd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_head),
    .status (q_stat)
  );

  fhsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> sv/fhsd_queue.sv
// ----------------------------------------------------------------------------
// fhsd_queue
// Small register queue of commands between the front and the back end.
// ----------------------------------------------------------------------------
module fhsd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fhsd_pkg::q_entry_t  wdata,
  input  logic                pop,
  output fhsd_pkg::q_entry_t  rdata,
  output fhsd_pkg::q_status_t status
);
  import fhsd_pkg::*;

  q_entry_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;

  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign rdata        = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("queue read while empty");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count lost a push");

endmodule

>>> sv/fhsd_front.sv
// ----------------------------------------------------------------------------
// fhsd_front
// Accepts stream bytes, holds and checks candidate headers, tags frame bytes
// and issues pass or release commands to the queue.
// ----------------------------------------------------------------------------
module fhsd_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fhsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fhsd_pkg::LEN_W-1:0]      cfg_data,
  input  fhsd_pkg::q_status_t             q_stat,
  output logic                            q_push,
  output fhsd_pkg::q_entry_t              q_wdata
);
  import fhsd_pkg::*;

  function automatic logic [2:0] trailer_len(input byte_t scheme);
    logic [2:0] len;
    len = 3'd2;
    if (scheme == 8'd1) begin
      len = 3'd1;
    end else if (scheme == 8'd4) begin
      len = 3'd4;
    end
    return len;
  endfunction

  logic [LEN_W-1:0]      min_payload_r, max_frame_r;
  byte_t                 win_r [WIN_DEPTH];
  byte_t                 win_nxt [WIN_DEPTH];
  logic [HOLD_CNT_W-1:0] hold_count_r, hold_count_nxt;
  logic                  in_frame_r, in_frame_nxt;
  logic [LEN_W-1:0]      bif_r, bif_nxt;
  logic [LEN_W-1:0]      frame_total_r, frame_total_nxt;
  logic [LEN_W-1:0]      payload_end_r, payload_end_nxt;
  logic [2:0]            cur_scheme_r, cur_scheme_nxt;

  logic        accept;
  logic        win_full;
  logic [15:0] decl_len, payload;
  logic [16:0] hdr_end, total;
  logic        hdr_good;
  logic        pass_last;
  logic [1:0]  pass_sec;

  assign in_tready = !q_stat.full;
  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;
  assign win_full  = (hold_count_r == HOLD_CNT_W'(WIN_DEPTH));

  // header check on the stored bytes plus the byte arriving now as scheme id
  always_comb begin
    decl_len = {win_r[4], win_r[5]};
    payload  = (decl_len < {5'b0, min_payload_r}) ? {5'b0, min_payload_r} : decl_len;
    hdr_end  = 17'(HEADER_BYTES) + {1'b0, payload};
    total    = hdr_end + {14'b0, trailer_len(in_tdata)};
    hdr_good = (in_tdata < 8'(NUM_SCHEMES)) && (payload <= {5'b0, max_frame_r})
               && (total <= {6'b0, max_frame_r});
  end

  always_comb begin
    pass_last = ({1'b0, bif_r} + 12'd1) >= {1'b0, frame_total_r};
    if (bif_r < LEN_W'(HEADER_BYTES)) begin
      pass_sec = SEC_HEADER;
    end else if (bif_r < payload_end_r) begin
      pass_sec = SEC_PAYLOAD;
    end else begin
      pass_sec = SEC_TRAILER;
    end
  end

  always_comb begin
    win_nxt         = win_r;
    hold_count_nxt  = hold_count_r;
    in_frame_nxt    = in_frame_r;
    bif_nxt         = bif_r;
    frame_total_nxt = frame_total_r;
    payload_end_nxt = payload_end_r;
    cur_scheme_nxt  = cur_scheme_r;
    q_push          = 1'b0;
    q_wdata         = '0;

    if (accept) begin
      if (in_frame_r) begin
        q_push           = 1'b1;
        q_wdata.kind     = KIND_PASS;
        q_wdata.bytes[0] = in_tdata;
        q_wdata.section  = pass_sec;
        q_wdata.scheme   = cur_scheme_r;
        q_wdata.last     = pass_last;
        if (pass_last) begin
          in_frame_nxt = 1'b0;
          bif_nxt      = '0;
        end else begin
          bif_nxt = bif_r + 1'b1;
        end
      end else if (!win_full) begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
          if (hold_count_r == HOLD_CNT_W'(i)) begin
            win_nxt[i] = in_tdata;
          end
        end
        hold_count_nxt = hold_count_r + 1'b1;
      end else if (!hdr_good) begin
        // drop the oldest byte and slide by one
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[WIN_DEPTH-1] = in_tdata;
      end else begin
        q_push          = 1'b1;
        q_wdata.kind    = KIND_RELEASE;
        for (int i = 0; i < WIN_DEPTH; i++) begin
          q_wdata.bytes[i] = win_r[i];
        end
        q_wdata.bytes[WIN_DEPTH] = in_tdata;
        q_wdata.section = SEC_HEADER;
        q_wdata.scheme  = in_tdata[2:0];
        // a frame is always longer than the held bytes
        q_wdata.last    = 1'b0;
        hold_count_nxt  = '0;
        in_frame_nxt    = 1'b1;
        bif_nxt         = LEN_W'(HOLD_DEPTH);
        frame_total_nxt = total[LEN_W-1:0];
        payload_end_nxt = hdr_end[LEN_W-1:0];
        cur_scheme_nxt  = in_tdata[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_payload_r <= MIN_PAYLOAD_RST;
      max_frame_r   <= MAX_FRAME_RST;
      hold_count_r  <= '0;
      in_frame_r    <= 1'b0;
      bif_r         <= '0;
      frame_total_r <= '0;
      payload_end_r <= '0;
      cur_scheme_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_PAYLOAD: min_payload_r <= cfg_data;
          REG_MAX_FRAME:   max_frame_r   <= cfg_data;
          default: ;
        endcase
      end
      hold_count_r  <= hold_count_nxt;
      in_frame_r    <= in_frame_nxt;
      bif_r         <= bif_nxt;
      frame_total_r <= frame_total_nxt;
      payload_end_r <= payload_end_nxt;
      cur_scheme_r  <= cur_scheme_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  a_frame_empty_window: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r |-> (hold_count_r == '0))
    else $error("window holds bytes during a frame");

  a_frame_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r |-> (bif_r < frame_total_r))
    else $error("frame position past frame end");

  a_release_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_wdata.kind == KIND_RELEASE) |=> in_frame_r)
    else $error("release without entering a frame");

endmodule

>>> sv/fhsd_back.sv
// ----------------------------------------------------------------------------
// fhsd_back
// Plays queue commands out onto the result stream through an output register;
// a release command gives its held bytes one per cycle while out_tready is high.
// ----------------------------------------------------------------------------
module fhsd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  fhsd_pkg::q_status_t q_stat,
  input  fhsd_pkg::q_entry_t  q_head,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,  // out_byte
  output logic [7:0]          out_tuser,  // section[1:0], scheme_id[4:2], frame_first[5]
  output logic                out_tlast   // frame_last
);
  import fhsd_pkg::*;

  logic                 out_valid_r, out_valid_nxt;
  byte_t                out_byte_r, out_byte_nxt;
  logic [1:0]           out_sec_r, out_sec_nxt;
  logic [2:0]           out_scheme_r, out_scheme_nxt;
  logic                 out_first_r, out_first_nxt;
  logic                 out_last_r, out_last_nxt;
  logic [REL_IDX_W-1:0] idx_r, idx_nxt;
  logic                 load;
  logic                 rel_end;

  assign load    = !q_stat.empty && (!out_valid_r || out_tready);
  assign rel_end = (idx_r == REL_IDX_W'(HOLD_DEPTH - 1));

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_tready;
    out_byte_nxt   = out_byte_r;
    out_sec_nxt    = out_sec_r;
    out_scheme_nxt = out_scheme_r;
    out_first_nxt  = out_first_r;
    out_last_nxt   = out_last_r;
    idx_nxt        = idx_r;
    q_pop          = 1'b0;

    if (load) begin
      out_valid_nxt  = 1'b1;
      out_sec_nxt    = q_head.section;
      out_scheme_nxt = q_head.scheme;
      if (q_head.kind == KIND_RELEASE) begin
        out_byte_nxt  = q_head.bytes[idx_r];
        out_first_nxt = (idx_r == '0);
        out_last_nxt  = q_head.last && rel_end;
        if (rel_end) begin
          idx_nxt = '0;
          q_pop   = 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end else begin
        out_byte_nxt  = q_head.bytes[0];
        out_first_nxt = 1'b0;
        out_last_nxt  = q_head.last;
        q_pop         = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r   <= out_byte_nxt;
    out_sec_r    <= out_sec_nxt;
    out_scheme_r <= out_scheme_nxt;
    out_first_r  <= out_first_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {2'b00, out_first_r, out_scheme_r, out_sec_r};
  assign out_tlast  = out_last_r;

  a_release_in_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != '0) |-> (!q_stat.empty && q_head.kind == KIND_RELEASE))
    else $error("release index set without a release at the head");

  a_first_is_header: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_first_r) |-> (out_sec_r == SEC_HEADER && !out_last_r))
    else $error("first byte of frame not tagged as header");

  a_first_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (load && q_head.kind == KIND_RELEASE && idx_r == '0) |=> out_first_r)
    else $error("release did not start with the first byte");

endmodule

>>> tb/frame_header_sync_deframer_tb.sv
// ----------------------------------------------------------------------------
// frame_header_sync_deframer_tb
// Self-checking bench: byte streams with frames, noise and bad headers go in,
// tagged frame bytes are checked against a cycle-free model of the deframer.
// ----------------------------------------------------------------------------
module frame_header_sync_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fhsd_pkg::*;

  // header byte offsets
  localparam int LEN_HI_POS = 4;
  localparam int LEN_LO_POS = 5;
  localparam int SCHEME_POS = 6;
  // schemes whose trailer is not two bytes
  localparam int SCHEME_SHORT_TRAILER = 1;
  localparam int SCHEME_LONG_TRAILER  = 4;
  localparam int LONG_HOLD_OFF = 300;

  typedef struct packed {
    byte_t      data;
    logic [1:0] section;
    logic [2:0] scheme;
    logic       first;
    logic       last;
  } frame_byte_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;
  logic [7:0]           out_tuser;
  logic                 out_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0]     cfg_data = '0;

  byte_t       pending_bytes[$];
  frame_byte_t expected_bytes[$];
  int          sent_cnt = 0;
  int          taken_cnt = 0;
  int          errors = 0;
  int          tx_gap = 0;
  int          rx_stall = 0;
  int          hold_off_req = 0;
  int          hold_off_seen = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;

  // deframer model, advanced once per accepted byte
  byte_t      win [HOLD_DEPTH];
  int         held = 0;
  bit         framing = 1'b0;
  int         frame_pos = 0;
  int         frame_len = 0;
  int         pay_end = 0;
  logic [2:0] scheme_cur = '0;
  int         min_pay_cfg = MIN_PAYLOAD_RST;
  int         max_frame_cfg = MAX_FRAME_RST;

  frame_header_sync_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int trailer_bytes(input int scheme);
    if (scheme == SCHEME_SHORT_TRAILER) return 1;
    if (scheme == SCHEME_LONG_TRAILER) return 4;
    return 2;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_result(input byte_t data, input int pos, input logic first,
                              input logic last);
    frame_byte_t r;
    r.data = data;
    if (pos < HEADER_BYTES) r.section = SEC_HEADER;
    else if (pos < pay_end) r.section = SEC_PAYLOAD;
    else r.section = SEC_TRAILER;
    r.scheme = scheme_cur;
    r.first  = first;
    r.last   = last;
    expected_bytes = {expected_bytes, r};
  endtask

  task automatic track_byte(input byte_t b);
    int   scheme;
    int   pay;
    int   tot;
    logic last;
    if (framing) begin
      last = (frame_pos + 1 >= frame_len);
      queue_result(b, frame_pos, 1'b0, last);
      frame_pos = (frame_pos + 1) % (1 << LEN_W);
      if (last) begin
        framing = 1'b0;
        frame_pos = 0;
      end
    end else begin
      if (held < HOLD_DEPTH) begin
        win[held] = b;
        held++;
      end
      if (held == HOLD_DEPTH) begin
        scheme = win[SCHEME_POS];
        pay = {win[LEN_HI_POS], win[LEN_LO_POS]};
        if (pay < min_pay_cfg) pay = min_pay_cfg;
        tot = HEADER_BYTES + pay + trailer_bytes(scheme);
        if (scheme >= NUM_SCHEMES || pay > max_frame_cfg || tot > max_frame_cfg) begin
          // bad header: drop the oldest byte and keep searching
          for (int i = 0; i < HOLD_DEPTH - 1; i++) win[i] = win[i + 1];
          held = HOLD_DEPTH - 1;
        end else begin
          scheme_cur = scheme[2:0];
          frame_len = tot;
          pay_end = HEADER_BYTES + pay;
          held = 0;
          framing = 1'b1;
          for (int i = 0; i < HOLD_DEPTH && framing; i++) begin
            last = (i + 1 >= frame_len);
            queue_result(win[i], i, i == 0, last);
            if (last) framing = 1'b0;
          end
          frame_pos = framing ? HOLD_DEPTH : 0;
        end
      end
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_byte(in_tdata);
        taken_cnt++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          in_tdata  <= pending_bytes.pop_front();
          in_tvalid <= 1'b1;
          tx_gap = tx_burst ? 0 : pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          $error("out_byte %0h arrived with nothing expected", out_tdata);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_tdata !== want.data) begin
            $error("out_byte: expected %0h, got %0h", want.data, out_tdata);
            errors++;
          end
          if (out_tuser[1:0] !== want.section) begin
            $error("section: expected %0d, got %0d", want.section, out_tuser[1:0]);
            errors++;
          end
          if (out_tuser[4:2] !== want.scheme) begin
            $error("scheme_id: expected %0d, got %0d", want.scheme, out_tuser[4:2]);
            errors++;
          end
          if (out_tuser[5] !== want.first) begin
            $error("frame_first: expected %0b, got %0b", want.first, out_tuser[5]);
            errors++;
          end
          if (out_tlast !== want.last) begin
            $error("frame_last: expected %0b, got %0b", want.last, out_tlast);
            errors++;
          end
        end
      end
      if (hold_off_req != hold_off_seen) begin
        hold_off_seen = hold_off_req;
        rx_stall = LONG_HOLD_OFF;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else if (!rx_burst && $urandom_range(0, 99) < 15) begin
        rx_stall = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input byte_t b);
    pending_bytes = {pending_bytes, b};
    sent_cnt++;
  endtask

  task automatic send_random_bytes(input int n);
    for (int i = 0; i < n; i++) send_byte(byte_t'($urandom_range(0, 255)));
  endtask

  // header bytes 0..3 stay above any scheme id or length high byte that could pass,
  // so the search locks onto the frame start and not onto a partial window
  task automatic send_frame(input int scheme, input int len);
    int pay;
    int tot;
    pay = (len < min_pay_cfg) ? min_pay_cfg : len;
    tot = HEADER_BYTES + pay + trailer_bytes(scheme);
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      case (i)
        LEN_HI_POS: send_byte(len[15:8]);
        LEN_LO_POS: send_byte(len[7:0]);
        SCHEME_POS: send_byte(scheme[7:0]);
        default:    send_byte(byte_t'($urandom_range(8, 255)));
      endcase
    end
    if (scheme < NUM_SCHEMES && pay <= max_frame_cfg && tot <= max_frame_cfg)
      send_random_bytes(tot - HOLD_DEPTH);
  endtask

  task automatic wait_sent();
    while (taken_cnt != sent_cnt) @(posedge clk);
  endtask

  // all bytes in, any open frame closed, all results out, then let the block go quiet
  task automatic settle();
    int waited;
    waited = 0;
    wait_sent();
    while (framing) begin
      send_random_bytes(frame_len - frame_pos);
      wait_sent();
    end
    while (expected_bytes.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_MIN_PAYLOAD) min_pay_cfg = val;
    else max_frame_cfg = val;
  endtask

  task automatic set_limits(input int min_pay, input int max_len);
    cfg_write(REG_MIN_PAYLOAD, min_pay[LEN_W-1:0]);
    cfg_write(REG_MAX_FRAME, max_len[LEN_W-1:0]);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset sizes: huge declared length is rejected, short length raised to the minimum;
    // receiver holds off at the start so the block fills up
    hold_off_req++;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(0, 16'hFFFF);
    send_frame(1, 0);
    settle();

    // largest minimum: every frame overflows
    set_limits(2047, 2047);
    send_frame(0, 0);
    settle();

    // tight maximum, back-to-back with no idling on either side: empty payload at
    // exactly the largest size, one frame over the size, and an unknown scheme
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    set_limits(0, 22);
    send_frame(0, 0);
    send_frame(4, 0);
    send_frame(NUM_SCHEMES, 0);
    settle();
    tx_burst = 1'b0;
    rx_burst = 1'b0;

    if (expected_bytes.size() != 0) begin
      $error("%0d expected bytes never came out", expected_bytes.size());
      errors++;
    end
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> frame_header_sync_deframer.f
sv/fhsd_pkg.sv
sv/fhsd_queue.sv
sv/fhsd_front.sv
sv/fhsd_back.sv
sv/frame_header_sync_deframer.sv
tb/frame_header_sync_deframer_tb.sv
